### hw/rtl/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Each macro checks a property on the rising clock edge and is disabled
// while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ahfd_pkg.sv
package ahfd_pkg;

    // Frame start character and frame layout, counted in bytes after the colon.
    localparam logic [7:0] FRAME_START = 8'h3A;
    localparam logic [3:0] POS_IDLE       = 4'd0;
    localparam logic [3:0] POS_INSTR_LAST = 4'd2;
    localparam logic [3:0] POS_VAL1_LAST  = 4'd6;
    localparam logic [3:0] POS_VAL2_LAST  = 4'd10;
    localparam logic [3:0] POS_CSUM_LAST  = 4'd12;
    localparam logic [3:0] POS_TRAILER    = 4'd13;

    // Width of the packed result beat, rounded up to whole bytes.
    localparam int RESULT_BITS = 41;
    localparam int TDATA_BITS  = 48;

    // One decoded frame.
    typedef struct packed {
        logic        checksum_ok;
        logic [15:0] value_two;
        logic [15:0] value_one;
        logic [7:0]  instruction;
    } result_t;

    // Hex character decode: bit 4 set means the character is not a hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        d = 5'h10;
        case (c) inside
            [8'h30:8'h39]: d = {1'b0, 4'(c - 8'h30)};
            [8'h61:8'h66]: d = {1'b0, 4'(c - 8'h57)};
            [8'h41:8'h46]: d = {1'b0, 4'(c - 8'h37)};
            default:       d = 5'h10;
        endcase
        return d;
    endfunction

endpackage

### hw/rtl/ahfd_parser.sv
`include "assert_macros.svh"

module ahfd_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,        // process byte_in this cycle
    input  logic [7:0]        byte_in,
    output logic              res_valid,   // a frame completes on this step
    output ahfd_pkg::result_t res
);
    import ahfd_pkg::*;

    logic [3:0]  pos_reg,   pos_next;
    logic [7:0]  xor_reg,   xor_next;
    logic [7:0]  instr_reg, instr_next;
    logic [15:0] val1_reg,  val1_next;
    logic [15:0] val2_reg,  val2_next;
    logic [7:0]  csum_reg,  csum_next;
    logic        ended_reg, ended_next;

    logic [4:0]  digit;
    logic        in_frame;
    logic        ended_eff;
    logic        take;

    assign digit    = hex_digit(byte_in);
    assign in_frame = (pos_reg != POS_IDLE) && (pos_reg <= POS_TRAILER);

    // A new field starts at the first byte of each of the four fields.
    assign ended_eff = (pos_reg == 4'd1 || pos_reg == 4'd3 || pos_reg == 4'd7 ||
                        pos_reg == 4'd11) ? 1'b0 : ended_reg;
    assign take      = !ended_eff && !digit[4];

    // Frame update for one byte.
    always_comb begin
        pos_next   = pos_reg;
        xor_next   = xor_reg;
        instr_next = instr_reg;
        val1_next  = val1_reg;
        val2_next  = val2_reg;
        csum_next  = csum_reg;
        ended_next = ended_reg;
        if (step) begin
            if (!in_frame) begin
                pos_next = POS_IDLE;
                if (byte_in == FRAME_START) begin
                    pos_next   = 4'd1;
                    xor_next   = FRAME_START;
                    instr_next = '0;
                    val1_next  = '0;
                    val2_next  = '0;
                    csum_next  = '0;
                    ended_next = 1'b0;
                end
            end else if (pos_reg == POS_TRAILER) begin
                pos_next = POS_IDLE;
            end else begin
                pos_next   = pos_reg + 4'd1;
                ended_next = ended_eff || digit[4];
                if (pos_reg <= POS_VAL2_LAST) begin
                    xor_next = xor_reg ^ byte_in;
                end
                if (take) begin
                    if (pos_reg <= POS_INSTR_LAST) begin
                        instr_next = {instr_reg[3:0], digit[3:0]};
                    end else if (pos_reg <= POS_VAL1_LAST) begin
                        val1_next = {val1_reg[11:0], digit[3:0]};
                    end else if (pos_reg <= POS_VAL2_LAST) begin
                        val2_next = {val2_reg[11:0], digit[3:0]};
                    end else begin
                        csum_next = {csum_reg[3:0], digit[3:0]};
                    end
                end
            end
        end
    end

    // The trailing byte releases the assembled frame.
    assign res_valid       = step && (pos_reg == POS_TRAILER);
    assign res.instruction = instr_reg;
    assign res.value_one   = val1_reg;
    assign res.value_two   = val2_reg;
    assign res.checksum_ok = (xor_reg == csum_reg);

    // Position counter and field registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= POS_IDLE;
            xor_reg   <= '0;
            instr_reg <= '0;
            val1_reg  <= '0;
            val2_reg  <= '0;
            csum_reg  <= '0;
            ended_reg <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            xor_reg   <= xor_next;
            instr_reg <= instr_next;
            val1_reg  <= val1_next;
            val2_reg  <= val2_next;
            csum_reg  <= csum_next;
            ended_reg <= ended_next;
        end
    end

    `ASSERT_IMPLY(a_pos_range, aclk, aresetn, 1'b1, pos_reg <= POS_TRAILER, "frame position out of range")
    `ASSERT_NEXT(a_done_idle, aclk, aresetn, res_valid, pos_reg == POS_IDLE, "frame did not close after trailer")
    `ASSERT_NEXT(a_start_pos, aclk, aresetn, step && pos_reg == POS_IDLE && byte_in == FRAME_START, pos_reg == 4'd1 && xor_reg == FRAME_START, "colon did not open a frame")

endmodule

### hw/rtl/ahfd_out_reg.sv
`include "assert_macros.svh"

module ahfd_out_reg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            load,       // capture a result beat
    input  ahfd_pkg::result_t               res,
    output logic                            room,       // register free at this edge
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [ahfd_pkg::TDATA_BITS-1:0] m_axis_tdata
);
    import ahfd_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    // The register can take a beat when empty or when its beat leaves now.
    assign room = !valid_reg || m_axis_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_axis_tready) begin
            valid_next = 1'b0;
        end
    end

    // Valid flag is reset; the payload is not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {(TDATA_BITS - RESULT_BITS)'(0), data_reg};

    `ASSERT_IMPLY(a_no_overwrite, aclk, aresetn, load, room, "result beat overwritten while stalled")

endmodule

### hw/rtl/ascii_hex_frame_deframer.sv
// ASCII hex frame deframer.
// The slave channel (s_axis_*) carries one received serial byte per beat.
// Bytes outside a frame are dropped until a colon is seen; the colon and the
// next 13 bytes form a frame: two hex characters of instruction, four of
// value one, four of value two, two of checksum and one unchecked trailer.
// The master channel (m_axis_*) carries one beat per complete frame with the
// decoded fields and a flag that tells whether the XOR of the colon and the
// ten instruction and value characters matches the received checksum.
// Throughput is one byte per cycle while the output register has room. A byte
// is held in the input register, then folded into the frame state; the result
// beat is loaded into the output register as the trailing byte is folded in.
// When the receiver stalls, the result beat holds in the output register and
// the byte behind it waits in the input register, so s_axis_tready falls only
// while both are full. Reset (aresetn low, synchronous) empties both
// registers and returns the parser to waiting for a colon.
`include "assert_macros.svh"

module ascii_hex_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // [7:0] instruction, [23:8] value_one,
                                        // [39:24] value_two, [40] checksum_ok
);
    import ahfd_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       room;
    logic       step;
    logic       res_valid;
    result_t    res;

    // A buffered byte is processed whenever the output register has room.
    assign step          = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || step;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    ahfd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .byte_in   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    ahfd_out_reg u_out_reg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (res_valid),
        .res           (res),
        .room          (room),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    `ASSERT_IMPLY(a_stall_full, aclk, aresetn, !s_axis_tready, in_valid_reg && m_axis_tvalid && !m_axis_tready, "input stalled without a full pipeline")

endmodule

### test/testbench.sv
module testbench;
    import ahfd_pkg::*;

    // ASCII codes used to build frames.
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    localparam int BYTE_TARGET = 1300;
    localparam int IDLE_PCT    = 6;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;            // [7:0] instruction, [23:8] value_one,
                                          // [39:24] value_two, [40] checksum_ok

    // A directed frame: its text, and optionally the decoded frame typed in by hand.
    typedef struct {
        string   text;
        bit      typed;
        result_t want;
    } frame_row_t;

    frame_row_t directed_frames[$];
    result_t    expected_frames[$];
    int         error_count = 0;
    bit         no_idle     = 1'b0;

    // Deframer state as the testbench tracks it.
    logic [3:0]  frame_pos   = POS_IDLE;
    logic [7:0]  running_xor = 8'h00;
    logic [7:0]  instr_acc   = 8'h00;
    logic [15:0] value1_acc  = 16'h0000;
    logic [15:0] value2_acc  = 16'h0000;
    logic [7:0]  csum_acc    = 8'h00;
    bit          field_done  = 1'b0;

    ascii_hex_frame_deframer uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock with a period of 10.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Returns 1 and the digit value when the character is a hex digit.
    function automatic bit hex_value(input logic [7:0] c, output logic [3:0] v);
        v = 4'h0;
        if (c >= CHAR_ZERO && c <= CHAR_ZERO + 8'd9) begin
            v = 4'(c - CHAR_ZERO);
            return 1'b1;
        end
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_A + 8'd5) begin
            v = 4'(c - CHAR_UPPER_A + 8'd10);
            return 1'b1;
        end
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_A + 8'd5) begin
            v = 4'(c - CHAR_LOWER_A + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Shifts one digit into a field; the first non-hex character freezes the field.
    function automatic logic [15:0] shift_digit(input logic [15:0] acc, input logic [7:0] c);
        logic [3:0] v;
        if (field_done)
            return acc;
        if (!hex_value(c, v)) begin
            field_done = 1'b1;
            return acc;
        end
        return {acc[11:0], v};
    endfunction

    // Folds one accepted byte into the frame state; done is set when a frame completes.
    task automatic deframe_byte(input logic [7:0] c, output bit done, output result_t frame);
        done  = 1'b0;
        frame = '0;
        if (frame_pos == POS_IDLE || frame_pos > POS_TRAILER) begin
            frame_pos = POS_IDLE;
            if (c == FRAME_START) begin
                frame_pos   = 4'd1;
                running_xor = FRAME_START;
                instr_acc   = 8'h00;
                value1_acc  = 16'h0000;
                value2_acc  = 16'h0000;
                csum_acc    = 8'h00;
                field_done  = 1'b0;
            end
        end else begin
            // Each field starts fresh on its first character.
            if (frame_pos == 4'd1 || frame_pos == POS_INSTR_LAST + 4'd1 ||
                frame_pos == POS_VAL1_LAST + 4'd1 || frame_pos == POS_VAL2_LAST + 4'd1)
                field_done = 1'b0;
            if (frame_pos <= POS_VAL2_LAST)
                running_xor ^= c;
            if (frame_pos <= POS_INSTR_LAST)
                instr_acc = 8'(shift_digit({8'h00, instr_acc}, c));
            else if (frame_pos <= POS_VAL1_LAST)
                value1_acc = shift_digit(value1_acc, c);
            else if (frame_pos <= POS_VAL2_LAST)
                value2_acc = shift_digit(value2_acc, c);
            else if (frame_pos <= POS_CSUM_LAST)
                csum_acc = 8'(shift_digit({8'h00, csum_acc}, c));
            else begin
                done              = 1'b1;
                frame.instruction = instr_acc;
                frame.value_one   = value1_acc;
                frame.value_two   = value2_acc;
                frame.checksum_ok = (running_xor == csum_acc);
            end
            frame_pos = done ? POS_IDLE : frame_pos + 4'd1;
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10)
            return CHAR_ZERO + 8'(n);
        return (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + 8'(n) - 8'd10;
    endfunction

    // A hex digit with the given chance in percent, otherwise a colon or any byte.
    function automatic logic [7:0] random_char(input int hex_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < hex_pct)
            return hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        if (roll < hex_pct + (100 - hex_pct) / 4)
            return FRAME_START;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic result_t frame_of(input logic [7:0] instr, input logic [15:0] v1,
                                         input logic [15:0] v2, input logic ok);
        result_t r;
        r.instruction = instr;
        r.value_one   = v1;
        r.value_two   = v2;
        r.checksum_ok = ok;
        return r;
    endfunction

    function automatic void add_row(input string text, input bit typed, input result_t want);
        frame_row_t row;
        row.text  = text;
        row.typed = typed;
        row.want  = want;
        directed_frames = {directed_frames, row};
    endfunction

    // Presents one byte, with an occasional idle cycle first, and predicts on acceptance.
    task automatic send_byte(input logic [7:0] c, output bit done);
        result_t frame;
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        deframe_byte(c, done, frame);
        if (done)
            expected_frames = {expected_frames, frame};
    endtask

    // Receiver side stalls at random, except during the quiet stretch.
    always @(posedge aclk) begin
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Compare each result beat with the oldest pending frame.
    always @(posedge aclk) begin
        result_t seen;
        result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            seen = result_t'(m_axis_tdata[RESULT_BITS-1:0]);
            if (expected_frames.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result beat: %h", seen);
            end else begin
                want = expected_frames.pop_front();
                if (seen.instruction !== want.instruction || seen.value_one !== want.value_one ||
                    seen.value_two !== want.value_two || seen.checksum_ok !== want.checksum_ok)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: exp instr %h v1 %h v2 %h ok %b, got %h %h %h %b",
                                 want.instruction, want.value_one, want.value_two,
                                 want.checksum_ok, seen.instruction, seen.value_one,
                                 seen.value_two, seen.checksum_ok);
                end
            end
        end
    end

    // Main stimulus: directed frames, then random frames with noise and cut-off frames.
    initial begin
        bit         done;
        logic [7:0] text[$];
        logic [7:0] sum;
        int         frame_bytes;
        int         frame_index;
        int         hex_pct;
        int         wait_cycles;
        int         last;
        int         noise_bytes;

        frame_bytes = 0;
        frame_index = 0;

        add_row(":00000000003A\n", 1'b1, frame_of(8'h00, 16'h0000, 16'h0000, 1'b1));
        add_row(":FFFFFFFFFF3A\n", 1'b1, frame_of(8'hFF, 16'hFFFF, 16'hFFFF, 1'b1));
        add_row(":ffffffffff3a\n", 1'b1, frame_of(8'hFF, 16'hFFFF, 16'hFFFF, 1'b1));
        add_row(":0000000000FF\n", 1'b1, frame_of(8'h00, 16'h0000, 16'h0000, 1'b0));
        // A non-hex checksum character ends the checksum early; odd trailer byte.
        add_row(":00000000003Z\377", 1'b1, frame_of(8'h00, 16'h0000, 16'h0000, 1'b0));
        // Noise while idle, top-bit bytes included.
        add_row("ab\r\n\200\377 ", 1'b0, '0);
        // A colon as trailer completes the frame and starts nothing.
        add_row(":00000000003A:", 1'b1, frame_of(8'h00, 16'h0000, 16'h0000, 1'b1));
        add_row(":1G.345z789CD\n", 1'b0, '0);
        add_row(":G1 23456789A\n", 1'b0, '0);
        add_row(":1:3:567:9AB:\n", 1'b0, '0);
        add_row(":\200\377\201a5\3768\3760000\n", 1'b0, '0);
        add_row(":@/\140g/:@G\140g0F\n", 1'b0, '0);
        add_row(":7f7FfF80000001\n", 1'b0, '0);
        // A cut-off frame swallows the next colon as data.
        add_row(":12AB", 1'b0, '0);
        add_row(":5A5a0F0f9e3C\n", 1'b0, '0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed frames.
        foreach (directed_frames[r]) begin
            last = directed_frames[r].text.len() - 1;
            for (int i = 0; i <= last; i++) begin
                send_byte(directed_frames[r].text[i], done);
                frame_bytes++;
                if (done && directed_frames[r].typed && i == last)
                    expected_frames[expected_frames.size() - 1] = directed_frames[r].want;
            end
        end

        // Random frames, mostly well formed with random content.
        while (frame_bytes < BYTE_TARGET) begin
            no_idle <= (frame_index >= 30 && frame_index < 45);

            if ($urandom_range(0, 99) < 20) begin
                noise_bytes = $urandom_range(1, 4);
                repeat (noise_bytes)
                    send_byte(8'($urandom_range(0, 255)), done);
                frame_bytes += noise_bytes;
            end

            hex_pct = ($urandom_range(0, 99) < 65) ? 97 : 70;
            text.delete();
            text = {text, FRAME_START};
            sum = FRAME_START;
            for (int i = 0; i < 10; i++) begin
                text = {text, random_char(hex_pct)};
                sum ^= text[text.size() - 1];
            end
            if ($urandom_range(0, 99) < 70) begin
                done = 1'($urandom_range(0, 1));
                text = {text, hex_char(sum[7:4], done)};
                text = {text, hex_char(sum[3:0], done)};
            end else begin
                text = {text, random_char(hex_pct)};
                text = {text, random_char(hex_pct)};
            end
            text = {text, (($urandom_range(0, 99) < 85) ? CHAR_NEWLINE
                                                         : 8'($urandom_range(0, 255)))};
            if ($urandom_range(0, 99) < 8)
                text = text[0:$urandom_range(0, 12)];

            foreach (text[i])
                send_byte(text[i], done);
            frame_bytes += text.size();
            frame_index++;
        end

        s_axis_tvalid <= 1'b0;
        no_idle       <= 1'b0;

        // Drain: give pending frames a bounded time to come out.
        wait_cycles = 0;
        while (expected_frames.size() != 0 && wait_cycles < 1000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (10) @(posedge aclk);
        if (expected_frames.size() != 0) begin
            error_count++;
            $display("%0d expected frames never arrived", expected_frames.size());
        end

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #3000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
